@@ rtl/core/pwm_tone_generator_macros.svh @@
// ----------------------------------------------------------------------------
// pwm_tone_generator assertion macros
// Shared concurrent assertion forms for the tone generator RTL.
// ----------------------------------------------------------------------------
`ifndef PWM_TONE_GENERATOR_MACROS_SVH
`define PWM_TONE_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define PWMT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pwmt assertion failed");

// Next-cycle implication.
`define PWMT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pwmt assertion failed");

`endif

@@ rtl/core/pwmt_pkg.sv @@
// ----------------------------------------------------------------------------
// pwmt_pkg
// Types, codes and constants shared by the tone generator modules.
// ----------------------------------------------------------------------------
package pwmt_pkg;

  localparam int TICKS_PER_SECOND_DEF = 1000000;

  localparam int FREQ_MIN  = 10;
  localparam int FREQ_MAX  = 5000;
  localparam int VOL_MAX   = 100;
  localparam int DUTY_DIV  = 200;
  localparam int MS_PER_S  = 1000;
  localparam int DUR_MAX   = 65535;

  localparam int FREQ_W = 13;   // holds FREQ_MAX
  localparam int VOL_W  = 7;    // holds VOL_MAX
  localparam int DUR_W  = 16;

  localparam int QDEPTH = 2;

  // request kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_PLAY = 2'd1;
  localparam logic [1:0] KIND_STOP = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_PLAY,
    OP_STOP,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] duration_ms;
    logic [15:0] frequency_hz;
    logic [7:0]  volume_pct;
  } req_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
  } rsp_t;

  // classified and clamped command held in the queue
  typedef struct packed {
    op_t               op;
    logic [DUR_W-1:0]  dur;
    logic [FREQ_W-1:0] freq;
    logic [VOL_W-1:0]  vol;
  } cmd_t;

endpackage

@@ rtl/core/pwmt_front.sv @@
// ----------------------------------------------------------------------------
// pwmt_front
// Accepts requests, decodes the kind, clamps frequency and volume and
// queues the resulting command for the back end.
// ----------------------------------------------------------------------------
module pwmt_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  pwmt_pkg::req_t req_data,
  output pwmt_pkg::cmd_t head,
  output logic           head_valid,
  input  logic           pop
);
  import pwmt_pkg::*;

  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  cmd_t              cmd;
  logic              push;

  // decode and clamp
  always_comb begin
    cmd.dur = req_data.duration_ms;
    unique case (req_data.kind)
      KIND_TICK: cmd.op = OP_TICK;
      KIND_PLAY: cmd.op = OP_PLAY;
      KIND_STOP: cmd.op = OP_STOP;
      default:   cmd.op = OP_NOP;
    endcase
    if (req_data.frequency_hz < 16'(FREQ_MIN)) begin
      cmd.freq = FREQ_W'(FREQ_MIN);
    end else if (req_data.frequency_hz > 16'(FREQ_MAX)) begin
      cmd.freq = FREQ_W'(FREQ_MAX);
    end else begin
      cmd.freq = req_data.frequency_hz[FREQ_W-1:0];
    end
    if (req_data.volume_pct > 8'(VOL_MAX)) begin
      cmd.vol = VOL_W'(VOL_MAX);
    end else begin
      cmd.vol = req_data.volume_pct[VOL_W-1:0];
    end
  end

  assign req_stall  = (count == QCNT_W'(QDEPTH));
  assign push       = req_valid && !req_stall;
  assign head_valid = (count != '0);
  assign head       = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/pwmt_div.sv @@
// ----------------------------------------------------------------------------
// pwmt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwmt_div #(
  parameter int DW = 27,
  parameter int VW = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dq;
  logic [VW-1:0]    rem;
  logic [VW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [VW:0]      rem_sh;
  logic [VW:0]      rem_sub;
  logic             ge;

  assign rem_sh   = {rem, dq[DW-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs};
  assign ge       = (rem_sh >= {1'b0, dvs});
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
      dq  <= {dq[DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/pwmt_back.sv @@
// ----------------------------------------------------------------------------
// pwmt_back
// Executes queued commands: tick stepping of the tone, stop, answers to
// unused kinds, and the play setup sequence of two divisions and a duty
// scale; drives the response register.
// ----------------------------------------------------------------------------
`include "pwm_tone_generator_macros.svh"

module pwmt_back #(
  parameter int TICKS_PER_SECOND = pwmt_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  pwmt_pkg::cmd_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output pwmt_pkg::rsp_t rsp_data
);
  import pwmt_pkg::*;

  localparam int TPM      = TICKS_PER_SECOND / MS_PER_S;
  localparam int PMAX     = TICKS_PER_SECOND / FREQ_MIN;
  localparam int PMIN     = TICKS_PER_SECOND / FREQ_MAX;
  localparam int PERIOD_W = $clog2(PMAX + 1);
  localparam int HIGH_W   = PERIOD_W - 1;
  localparam int DT_W     = $clog2(DUR_MAX * TPM + 1);
  localparam int CYC_W    = $clog2(DUR_MAX * TPM / PMIN + 1);
  localparam int PROD_W   = PERIOD_W + VOL_W;
  localparam int TPS_W    = $clog2(TICKS_PER_SECOND + 1);
  localparam int DW_A     = (DT_W > PROD_W) ? DT_W : PROD_W;
  localparam int DW       = (DW_A > TPS_W) ? DW_A : TPS_W;
  localparam int VW_A     = (PERIOD_W > FREQ_W) ? PERIOD_W : FREQ_W;
  localparam int VW       = (VW_A > 8) ? VW_A : 8;

  // 200 = 8 * 25: drop the 8 with a shift, then multiply by a rounded-up
  // reciprocal of 25 that is exact over the whole product range
  localparam int     DUTY_SH    = 3;
  localparam int     DUTY_ODD   = DUTY_DIV >> DUTY_SH;
  localparam int     RECIP_SH   = PROD_W + 2;
  localparam int     RECIP_W    = RECIP_SH - 4;
  localparam longint RECIP_ODD  = ((longint'(1) <<< RECIP_SH) + DUTY_ODD - 1) / DUTY_ODD;
  localparam int     HPROD_W    = PROD_W - DUTY_SH + RECIP_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_P,
    ST_MUL_H,
    ST_DIV_H,
    ST_DIV_C
  } state_t;

  state_t              state;
  logic [PERIOD_W-1:0] period_us;
  logic [HIGH_W-1:0]   high_time_us;
  logic [CYC_W-1:0]    cycles_total;
  logic [PERIOD_W-1:0] phase_us;
  logic [CYC_W-1:0]    cycles_done;
  logic                playing;

  logic [PERIOD_W-1:0] period_new;
  logic [HIGH_W-1:0]   high_new;
  logic [DT_W-1:0]     dur_ticks;
  logic [VOL_W-1:0]    vol_c;
  logic [PROD_W-1:0]   duty_prod;
  logic [HPROD_W-1:0]  duty_scaled;

  logic                div_start;
  logic [DW-1:0]       div_dividend;
  logic [VW-1:0]       div_divisor;
  logic                div_done;
  logic [DW-1:0]       div_quot;

  logic                tick_level;
  logic [PERIOD_W-1:0] phase_inc;
  logic [CYC_W-1:0]    done_inc;
  logic                wrap;
  logic                finish;

  pwmt_div #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign pop = head_valid && (state == ST_IDLE) && (!rsp_valid || !rsp_stall);

  // tick step of the running tone
  assign tick_level = playing && (phase_us < {1'b0, high_time_us});
  assign phase_inc  = phase_us + 1'b1;
  assign wrap       = (phase_inc >= period_us);
  assign done_inc   = cycles_done + 1'b1;
  assign finish     = wrap && (done_inc >= cycles_total);

  // duty scale: high time = period * volume / 200
  assign duty_scaled = HPROD_W'(duty_prod[PROD_W-1:DUTY_SH]) * HPROD_W'(RECIP_ODD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rsp_valid    <= 1'b0;
      playing      <= 1'b0;
      period_us    <= '0;
      high_time_us <= '0;
      cycles_total <= '0;
      phase_us     <= '0;
      cycles_done  <= '0;
      div_start    <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            unique case (head.op)
              OP_TICK: begin
                rsp_valid          <= 1'b1;
                rsp_data.pin_level <= tick_level;
                rsp_data.busy_res  <= playing && !finish;
                if (playing) begin
                  phase_us <= wrap ? '0 : phase_inc;
                  if (wrap) begin
                    cycles_done <= done_inc;
                  end
                  if (finish) begin
                    playing <= 1'b0;
                  end
                end
              end
              OP_PLAY: begin
                dur_ticks    <= DT_W'(head.dur) * DT_W'(TPM);
                vol_c        <= head.vol;
                div_dividend <= DW'(TICKS_PER_SECOND);
                div_divisor  <= VW'(head.freq);
                div_start    <= 1'b1;
                state        <= ST_DIV_P;
              end
              OP_STOP: begin
                playing            <= 1'b0;
                phase_us           <= '0;
                cycles_done        <= '0;
                rsp_valid          <= 1'b1;
                rsp_data.pin_level <= 1'b0;
                rsp_data.busy_res  <= 1'b0;
              end
              OP_NOP: begin
                rsp_valid          <= 1'b1;
                rsp_data.pin_level <= 1'b0;
                rsp_data.busy_res  <= playing;
              end
            endcase
          end
        end
        ST_DIV_P: begin
          if (div_done) begin
            period_new <= div_quot[PERIOD_W-1:0];
            state      <= ST_MUL_H;
          end
        end
        ST_MUL_H: begin
          duty_prod <= PROD_W'(period_new) * PROD_W'(vol_c);
          state     <= ST_DIV_H;
        end
        ST_DIV_H: begin
          high_new     <= duty_scaled[RECIP_SH +: HIGH_W];
          div_dividend <= DW'(dur_ticks);
          div_divisor  <= VW'(period_new);
          div_start    <= 1'b1;
          state        <= ST_DIV_C;
        end
        ST_DIV_C: begin
          if (div_done) begin
            period_us          <= period_new;
            high_time_us       <= high_new;
            cycles_total       <= div_quot[CYC_W-1:0];
            phase_us           <= '0;
            cycles_done        <= '0;
            playing            <= (div_quot != '0);
            rsp_valid          <= 1'b1;
            rsp_data.pin_level <= 1'b0;
            rsp_data.busy_res  <= (div_quot != '0);
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `PWMT_ASSERT_IMP(a_phase_in_period, clk, rst, playing, phase_us < period_us)
  `PWMT_ASSERT_IMP(a_cycles_in_range, clk, rst, playing, cycles_done < cycles_total)
  `PWMT_ASSERT_IMP(a_done_in_setup, clk, rst, div_done, state != ST_IDLE)
  `PWMT_ASSERT_NXT(a_play_answers, clk, rst, (state == ST_DIV_C) && div_done, rsp_valid)

endmodule

@@ rtl/core/pwm_tone_generator.sv @@
// Tick, stop and unused-kind requests pass the queue, then the response register.
// A play is answered once its setup is done: two runs of one radix-2 divider
//   (period, cycle count) plus the duty scale.
// Throughput: one tick request per cycle while rsp_stall is low; a play holds the
//   back end for its whole setup while the two-entry queue takes up to two more requests.
// Reset: synchronous, active high; tone idle, queue and response register empty.
// ----------------------------------------------------------------------------
// pwm_tone_generator
// Buzzer tone generator stepped by one-microsecond tick requests.
// ----------------------------------------------------------------------------
module pwm_tone_generator #(
  parameter int TICKS_PER_SECOND = pwmt_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic           clk,
  input  logic           rst,
  // request channel
  input  logic           req_valid,
  output logic           req_stall,
  input  pwmt_pkg::req_t req_data,
  // response channel, one response per request
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output pwmt_pkg::rsp_t rsp_data
);
  import pwmt_pkg::*;

  // Front end: decode kind, clamp frequency to 10..5000 Hz and volume to
  // 0..100 percent, and hold the command in a small queue so request intake
  // goes on during a running play setup until the queue is full.
  cmd_t head;
  logic head_valid;
  logic pop;

  pwmt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_data),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // Back end: advance the tone on each tick, drop it on stop, and on play
  // compute period and cycle count with the shared divider and the high
  // time with a reciprocal multiply before restarting the tone. Results
  // land in a response register that frees itself in the same cycle it is
  // taken, so the next command can issue without a bubble.
  pwmt_back #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp_data   (rsp_data)
  );

endmodule
